// File: rtl/sopl_pkg.sv
// Shared types and constants of the stereo one-pole low-pass block.
package sopl_pkg;

  // Gain register format: unsigned Q1.14, 16384 is unity.
  localparam int GAIN_BITS = 15;
  localparam int GAIN_FRAC = 14;
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 15'd16384;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_COEF  = 2'd0,
    CFG_GAIN_LEVEL = 2'd1,
    CFG_BYPASS_ON  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Steps of one channel on the shared multiplier.
  typedef enum logic [2:0] {
    PH_MUL_AX = 3'd0,
    PH_MUL_PH = 3'd1,
    PH_SUM    = 3'd2,
    PH_MUL_FG = 3'd3,
    PH_STORE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_FILTER = 2'd0,
    MODE_PASS   = 2'd1,
    MODE_MUTE   = 2'd2
  } mode_t;

  // Strobes from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

endpackage

// File: rtl/sopl_in_if.sv
// Input frame channel: valid/ready handshake with one stereo frame.
interface sopl_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          silent_in;
  logic                          block_end;

  modport source (output valid, left_in, right_in, silent_in, block_end, input ready);
  modport sink   (input valid, left_in, right_in, silent_in, block_end, output ready);
endinterface

// File: rtl/sopl_out_if.sv
// Result channel: valid/ready handshake with one filtered frame and peak report.
interface sopl_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          muted;
  logic [SAMPLE_BITS-2:0]        peak_level;
  logic                          peak_valid;
  logic                          peak_changed;

  modport source (output valid, left_out, right_out, muted, peak_level, peak_valid,
                  peak_changed, input ready);
  modport sink   (input valid, left_out, right_out, muted, peak_level, peak_valid,
                  peak_changed, output ready);
endinterface

// File: rtl/stereo_one_pole_lowpass_gain_top.sv
// Top level of the stereo one-pole low-pass filter with gain and block peak meter.
//
// Usage:
//   in_ch  takes one stereo frame per transaction (valid and ready high at a clock edge).
//   out_ch returns exactly one result per frame, in order, through an output register.
//   cfg_we/cfg_index/cfg_data write pole_coef (0), gain_level (1) and bypass_on (2);
//   write them only while no frame is in flight.
// Sequence:
//   A filtered frame runs through the single shared multiplier in five steps per
//   channel (a*x, p*h, sum, f*gain, round and saturate), left then right, and then
//   loads the output register. Bypassed or muted frames skip the multiplier and go
//   straight to the output register. The block takes a new frame only after the last
//   one has been loaded into the output register.
// Reset:
//   rst_n low at a clock edge clears both channel histories, the running and the
//   reported peak, and loads pole 0, unity gain, bypass off. No result is pending.
// Stall:
//   While out_ch holds a result that is not taken, the block still accepts and works
//   on the next frame, then holds it finished until the output register frees up.
module stereo_one_pole_lowpass_gain_top import sopl_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sopl_in_if.sink               in_ch,
  sopl_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [((COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS)-1:0] cfg_data
);

  // Multiplier operand widths: A carries samples, history and the pre-gain sum,
  // B carries the two coefficients (one of which may be exactly 2^COEF_BITS) or the gain.
  localparam int AW = SAMPLE_BITS + 1;
  localparam int BW = (COEF_BITS + 2 > GAIN_BITS + 1) ? COEF_BITS + 2 : GAIN_BITS + 1;
  localparam int PW = AW + BW;

  localparam logic signed [PW-1:0] GAIN_RND = {{(PW-1){1'b0}}, 1'b1} << (GAIN_FRAC - 1);
  localparam logic signed [PW-1:0] SAT_HI   = PW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO   = ~SAT_HI;

  // Configuration registers.
  logic [COEF_BITS-1:0] pole_coef_r;
  logic [GAIN_BITS-1:0] gain_level_r;
  logic                 bypass_on_r;

  // Sequencer.
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   ch_r, ch_nxt;
  mac_ctl_t mac_ctl;
  logic   store_y;
  logic   out_load;

  // Frame held while it is worked on.
  logic signed [SAMPLE_BITS-1:0] xl_r, xr_r;
  logic                          last_r;
  logic                          report_r;
  mode_t                         mode_r;

  // Filter state.
  logic signed [SAMPLE_BITS-1:0] lhist_r, rhist_r;
  logic [SAMPLE_BITS-2:0]        running_peak_r, previous_peak_r;

  // Output register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;
  logic                          out_muted_r;
  logic [SAMPLE_BITS-2:0]        out_peak_r;
  logic                          out_pvalid_r, out_pchanged_r;

  // Datapath.
  logic                          in_accept;
  mode_t                         mode_in;
  logic [COEF_BITS:0]            a_coef;
  logic signed [SAMPLE_BITS-1:0] x_sel, h_sel;
  logic signed [AW-1:0]          op_a;
  logic signed [BW-1:0]          op_b;
  logic signed [PW-1:0]          prod, acc;
  logic signed [PW-1:0]          y_rnd, y_sh;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          peak_up;
  logic                          rep_now;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Silence wins over bypass; zero gain mutes only outside bypass.
  always_comb begin
    priority if (in_ch.silent_in) begin
      mode_in = MODE_MUTE;
    end else if (bypass_on_r) begin
      mode_in = MODE_PASS;
    end else if (gain_level_r == '0) begin
      mode_in = MODE_MUTE;
    end else begin
      mode_in = MODE_FILTER;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_coef_r  <= '0;
      gain_level_r <= GAIN_UNITY;
      bypass_on_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POLE_COEF:  pole_coef_r  <= cfg_data[COEF_BITS-1:0];
        CFG_GAIN_LEVEL: gain_level_r <= cfg_data[GAIN_BITS-1:0];
        CFG_BYPASS_ON:  bypass_on_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MUL_AX;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Next state and strobes: one multiplier step per cycle, left channel then right.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ch_nxt    = ch_r;
    mac_ctl   = '0;
    store_y   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (mode_in == MODE_FILTER) ? ST_CALC : ST_DONE;
          phase_nxt = PH_MUL_AX;
          ch_nxt    = 1'b0;
        end
      end
      ST_CALC: begin
        unique case (phase_r)
          PH_MUL_AX: begin
            mac_ctl.mul_en = 1'b1;
            phase_nxt      = PH_MUL_PH;
          end
          PH_MUL_PH: begin
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.acc_load = 1'b1;
            phase_nxt        = PH_SUM;
          end
          PH_SUM: begin
            mac_ctl.acc_add = 1'b1;
            phase_nxt       = PH_MUL_FG;
          end
          PH_MUL_FG: begin
            mac_ctl.mul_en = 1'b1;
            phase_nxt      = PH_STORE;
          end
          PH_STORE: begin
            store_y   = 1'b1;
            phase_nxt = PH_MUL_AX;
            if (ch_r) begin
              state_nxt = ST_DONE;
            end else begin
              ch_nxt = 1'b1;
            end
          end
          default: phase_nxt = PH_MUL_AX;
        endcase
      end
      ST_DONE: begin
        // Hold the finished frame until the output register is free.
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  assign a_coef = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, pole_coef_r};
  assign x_sel  = ch_r ? xr_r : xl_r;
  assign h_sel  = ch_r ? rhist_r : lhist_r;

  always_comb begin
    unique case (phase_r)
      PH_MUL_AX: begin
        op_a = AW'(x_sel);
        op_b = $signed(BW'(a_coef));
      end
      PH_MUL_PH: begin
        op_a = AW'(h_sel);
        op_b = $signed(BW'(pole_coef_r));
      end
      default: begin
        // Rounded pre-gain sum: the rounding half is already in the accumulator.
        op_a = $signed(acc[COEF_BITS +: AW]);
        op_b = $signed(BW'(gain_level_r));
      end
    endcase
  end

  sopl_mac #(
    .AW        (AW),
    .BW        (BW),
    .RND_SHIFT (COEF_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  // Round the gain product half up, then clamp to the sample range.
  always_comb begin
    y_rnd = prod + GAIN_RND;
    y_sh  = y_rnd >>> GAIN_FRAC;
    if (y_sh > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y_sh < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_sh[SAMPLE_BITS-1:0];
    end
  end

  // Only a positive right output raises the peak.
  assign peak_up = ch_r && !y_sat[SAMPLE_BITS-1] &&
                   (y_sat[SAMPLE_BITS-2:0] > running_peak_r);
  assign rep_now = last_r && report_r;

  // Frame capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      xl_r     <= in_ch.left_in;
      xr_r     <= in_ch.right_in;
      last_r   <= in_ch.block_end;
      report_r <= !in_ch.silent_in && !bypass_on_r;
      mode_r   <= mode_in;
    end
  end

  // Filter history and peak tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhist_r         <= '0;
      rhist_r         <= '0;
      running_peak_r  <= '0;
      previous_peak_r <= '0;
    end else begin
      if (store_y) begin
        if (ch_r) begin
          rhist_r <= y_sat;
        end else begin
          lhist_r <= y_sat;
        end
        if (peak_up) begin
          running_peak_r <= y_sat[SAMPLE_BITS-2:0];
        end
      end
      if (out_load && last_r) begin
        running_peak_r <= '0;
        if (report_r) begin
          previous_peak_r <= running_peak_r;
        end
      end
    end
  end

  // Output register: valid control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (mode_r)
        MODE_FILTER: begin
          out_left_r  <= lhist_r;
          out_right_r <= rhist_r;
        end
        MODE_PASS: begin
          out_left_r  <= xl_r;
          out_right_r <= xr_r;
        end
        default: begin
          out_left_r  <= '0;
          out_right_r <= '0;
        end
      endcase
      out_muted_r    <= (mode_r == MODE_MUTE);
      out_peak_r     <= rep_now ? running_peak_r : '0;
      out_pvalid_r   <= rep_now;
      out_pchanged_r <= rep_now && (running_peak_r != previous_peak_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_out     = out_left_r;
  assign out_ch.right_out    = out_right_r;
  assign out_ch.muted        = out_muted_r;
  assign out_ch.peak_level   = out_peak_r;
  assign out_ch.peak_valid   = out_pvalid_r;
  assign out_ch.peak_changed = out_pchanged_r;

  // A frame occupies the block: no second transaction right behind it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("input taken again right after a transaction");

  a_mute_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.muted) |-> (out_ch.left_out == '0 && out_ch.right_out == '0))
    else $error("muted result carries nonzero samples");

  a_peak_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.peak_valid) |->
      (!out_ch.peak_changed && out_ch.peak_level == '0))
    else $error("peak fields set without a peak report");

  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (running_peak_r == '0))
    else $error("running peak not cleared after block end");

endmodule

// File: rtl/sopl_mac.sv
// Shared signed multiplier with registered product and rounding accumulator.
module sopl_mac import sopl_pkg::*; #(
  parameter int AW        = 25,
  parameter int BW        = 18,
  parameter int RND_SHIFT = 16
) (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [AW-1:0]     op_a,
  input  logic signed [BW-1:0]     op_b,
  output logic signed [AW+BW-1:0]  prod,
  output logic signed [AW+BW-1:0]  acc
);

  localparam int PW = AW + BW;
  // Half an LSB of the final shift, preloaded so the shift is a plain slice.
  localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (RND_SHIFT - 1);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    priority if (ctl.acc_load) begin
      acc_r <= prod_r + RND;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the stereo one-pole low-pass filter with gain and peak meter.
`timescale 1ns / 1ps

module tb_top;
  import sopl_pkg::*;

  localparam int SB          = 24;
  localparam int COEF_BITS   = 16;
  localparam int CFG_W       = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS;
  localparam int N_SEG       = 12;    // random segments, each with its own register setting
  localparam int SEG_ITEMS   = 62;    // frames per random segment
  localparam int HOLD_SEG    = 5;     // segment in which the sender waits for a full drain
  localparam int TAIL_CYCLES = 24;    // quiet time after the last result
  localparam int QUIET_LIMIT = 2000;  // cycles without any transaction before giving up

  localparam logic [SB-1:0]        SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]        SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-2:0]        PMAX = {(SB-1){1'b1}};
  localparam logic [GAIN_BITS-1:0] GMAX = {GAIN_BITS{1'b1}};
  localparam longint               SAT_HI = (64'sd1 <<< (SB-1)) - 1;
  localparam longint               SAT_LO = -SAT_HI - 1;

  // One stereo frame as the sender drives it.
  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
    logic          silent;
    logic          last;
  } frame_t;

  // One result as the block returns it.
  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
    logic          muted;
    logic [SB-2:0] peak;
    logic          pvalid;
    logic          pchanged;
  } frame_res_t;

  // Directed row: register setting, frame, and optionally a result typed in by hand.
  typedef struct packed {
    logic [COEF_BITS-1:0] pole;
    logic [GAIN_BITS-1:0] gain;
    logic                 byp;
    frame_t               frame;
    logic                 lit;
    frame_res_t           res;
  } dir_row_t;

  localparam int N_DIR = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sopl_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  sopl_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  stereo_one_pole_lowpass_gain_top #(
    .SAMPLE_BITS(SB),
    .COEF_BITS  (COEF_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's registers and filter state.
  logic [COEF_BITS-1:0] pole_r;
  logic [GAIN_BITS-1:0] gain_r;
  logic                 byp_r;
  logic [SB-1:0]        left_hist;
  logic [SB-1:0]        right_hist;
  logic [SB-2:0]        run_peak;
  logic [SB-2:0]        last_peak;

  frame_res_t filtered_q[$];   // results still owed by the block, oldest first
  int         mismatch_cnt;
  int         quiet_cycles;
  int         snd_idle_pct;
  int         rcv_stall_pct;

  dir_row_t dir_tab [N_DIR];

  // Print one line per discrepancy and count it.
  task automatic report_mismatch(input string what, input logic [SB-1:0] want,
                                 input logic [SB-1:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // One channel of the recursion: weighted sum rounded to sample scale, then the gain
  // rounded and clamped. The clamped value becomes the new history.
  function automatic logic [SB-1:0] lowpass_step(input logic [SB-1:0] x,
                                                 inout logic [SB-1:0] hist);
    longint p;
    longint a;
    longint f;
    longint y;
    p = longint'(pole_r);
    a = (64'sd1 <<< COEF_BITS) - p;
    f = (a * longint'(signed'(x)) + p * longint'(signed'(hist)) + (64'sd1 <<< (COEF_BITS-1)))
        >>> COEF_BITS;
    y = (f * longint'(gain_r) + (64'sd1 <<< (GAIN_FRAC-1))) >>> GAIN_FRAC;
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    hist = y[SB-1:0];
    return y[SB-1:0];
  endfunction

  // Work out the result of one frame and advance the shadow state.
  function automatic frame_res_t lowpass_frame(input frame_t f);
    frame_res_t r;
    r = '0;
    if (f.silent) begin
      r.muted = 1'b1;
    end else if (byp_r) begin
      r.left  = f.left;
      r.right = f.right;
    end else if (gain_r == '0) begin
      r.muted = 1'b1;
    end else begin
      r.left  = lowpass_step(f.left, left_hist);
      r.right = lowpass_step(f.right, right_hist);
      // Only a positive right output can raise the block peak.
      if (!r.right[SB-1] && r.right != '0 && r.right[SB-2:0] > run_peak)
        run_peak = r.right[SB-2:0];
    end
    if (f.last) begin
      if (!f.silent && !byp_r) begin
        r.peak     = run_peak;
        r.pvalid   = 1'b1;
        r.pchanged = (run_peak != last_peak);
        last_peak  = run_peak;
      end
      run_peak = '0;
    end
    return r;
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMAX;
      1:       return SMIN;
      2:       return SB'(int'($urandom_range(400)) - 200);
      3:       return $urandom_range(1) ? '1 : '0;
      default: return SB'($urandom);
    endcase
  endfunction

  // Drop valid, then hold until every owed result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  // Write all three registers while the block is idle. The unused upper data bits
  // carry random junk, which the block must drop.
  task automatic load_config(input logic [COEF_BITS-1:0] pole,
                             input logic [GAIN_BITS-1:0] gain, input logic byp);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLE_COEF;
    cfg_data  <= CFG_W'(pole);
    @(posedge clk);
    cfg_index <= CFG_GAIN_LEVEL;
    cfg_data  <= {(CFG_W-GAIN_BITS)'($urandom), gain};
    @(posedge clk);
    cfg_index <= CFG_BYPASS_ON;
    cfg_data  <= {(CFG_W-1)'($urandom), byp};
    @(posedge clk);
    cfg_we <= 1'b0;
    pole_r = pole;
    gain_r = gain;
    byp_r  = byp;
  endtask

  // Offer one frame, idling first at the current rate, and on the transaction
  // queue the hand-typed result or else the predicted one.
  task automatic send_frame(input frame_t f, input logic lit, input frame_res_t lit_res);
    frame_res_t want;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.left_in   <= f.left;
    in_ch.right_in  <= f.right;
    in_ch.silent_in <= f.silent;
    in_ch.block_end <= f.last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    want = lowpass_frame(f);
    filtered_q.push_back(lit ? lit_res : want);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Check every result transaction against the oldest owed result, field by field.
  always @(posedge clk) begin
    frame_res_t got;
    frame_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.left_out, out_ch.right_out, out_ch.muted, out_ch.peak_level,
              out_ch.peak_valid, out_ch.peak_changed};
      if (filtered_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got.right);
      end else begin
        want = filtered_q.pop_front();
        if (got.left !== want.left) report_mismatch("left_out", want.left, got.left);
        if (got.right !== want.right) report_mismatch("right_out", want.right, got.right);
        if (got.muted !== want.muted)
          report_mismatch("muted", SB'(want.muted), SB'(got.muted));
        if (got.peak !== want.peak)
          report_mismatch("peak_level", SB'(want.peak), SB'(got.peak));
        if (got.pvalid !== want.pvalid)
          report_mismatch("peak_valid", SB'(want.pvalid), SB'(got.pvalid));
        if (got.pchanged !== want.pchanged)
          report_mismatch("peak_changed", SB'(want.pchanged), SB'(got.pchanged));
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: end the run if the block stops moving.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** stereo_one_pole_lowpass_gain_top: FAILED **");
    $finish;
  end

  initial begin
    frame_t f;
    logic [COEF_BITS-1:0] pole;
    logic [GAIN_BITS-1:0] gain;

    // Directed rows. Typed-in results are the cases one can read off by hand:
    // unity pass-through at pole zero, the sample extremes, peak report and its
    // change flag, silence, zero gain, bypass, and silence winning over bypass.
    dir_tab = '{
      // reset setting: pole 0 and unity gain pass the input through exactly
      '{16'd0, GAIN_UNITY, 1'b0, '{24'd1000, 24'd2000, 1'b0, 1'b0}, 1'b1,
        '{24'd1000, 24'd2000, 1'b0, 23'd0, 1'b0, 1'b0}},
      // block end with a negative right output: report the earlier peak
      '{16'd0, GAIN_UNITY, 1'b0, '{SMAX, SMIN, 1'b0, 1'b1}, 1'b1,
        '{SMAX, SMIN, 1'b0, 23'd2000, 1'b1, 1'b1}},
      '{16'd0, GAIN_UNITY, 1'b0, '{SMIN, SMAX, 1'b0, 1'b1}, 1'b1,
        '{SMIN, SMAX, 1'b0, PMAX, 1'b1, 1'b1}},
      // same peak twice: change flag drops
      '{16'd0, GAIN_UNITY, 1'b0, '{SMIN, SMAX, 1'b0, 1'b1}, 1'b1,
        '{SMIN, SMAX, 1'b0, PMAX, 1'b1, 1'b0}},
      // silent block end: zero out, no report
      '{16'd0, GAIN_UNITY, 1'b0, '{24'd123, 24'd456, 1'b1, 1'b1}, 1'b1,
        '{24'd0, 24'd0, 1'b1, 23'd0, 1'b0, 1'b0}},
      // zero gain: muted, but the block end still reports the (cleared) peak
      '{16'd0, 15'd0, 1'b0, '{24'd5000, 24'd6000, 1'b0, 1'b1}, 1'b1,
        '{24'd0, 24'd0, 1'b1, 23'd0, 1'b1, 1'b1}},
      // bypass wins over zero gain, and a bypassed block end makes no report
      '{16'd0, 15'd0, 1'b1, '{-24'sd7, 24'd9, 1'b0, 1'b1}, 1'b1,
        '{-24'sd7, 24'd9, 1'b0, 23'd0, 1'b0, 1'b0}},
      '{16'd0, 15'd0, 1'b1, '{24'd300, 24'd400, 1'b1, 1'b0}, 1'b1,
        '{24'd0, 24'd0, 1'b1, 23'd0, 1'b0, 1'b0}},
      '{16'd0, 15'd0, 1'b1, '{SMAX, SMIN, 1'b0, 1'b0}, 1'b1,
        '{SMAX, SMIN, 1'b0, 23'd0, 1'b0, 1'b0}},
      // largest gain on full-scale input: clamp at both ends
      '{16'd0, GMAX, 1'b0, '{SMAX, SMIN, 1'b0, 1'b0}, 1'b1,
        '{SMAX, SMIN, 1'b0, 23'd0, 1'b0, 1'b0}},
      '{16'd0, GMAX, 1'b0, '{-24'sd1, 24'd1, 1'b0, 1'b1}, 1'b0, '0},
      // largest pole: history dominates
      '{16'hFFFF, GAIN_UNITY, 1'b0, '{SMAX, SMIN, 1'b0, 1'b0}, 1'b0, '0},
      '{16'hFFFF, GAIN_UNITY, 1'b0, '{SMIN, SMAX, 1'b0, 1'b0}, 1'b0, '0},
      '{16'hFFFF, GAIN_UNITY, 1'b0, '{24'd0, 24'd0, 1'b0, 1'b1}, 1'b0, '0},
      '{16'h8000, GAIN_UNITY, 1'b0, '{SMAX, SMAX, 1'b0, 1'b0}, 1'b0, '0},
      '{16'h8000, GAIN_UNITY, 1'b0, '{-24'sd1000, -24'sd1000, 1'b0, 1'b1}, 1'b0, '0},
      // smallest nonzero gain: rounding of tiny products
      '{16'd0, 15'd1, 1'b0, '{SMAX, SMIN, 1'b0, 1'b0}, 1'b0, '0},
      '{16'd0, 15'd1, 1'b0, '{-24'sd8193, 24'd8192, 1'b0, 1'b1}, 1'b0, '0},
      // silence wins over bypass, block end included
      '{16'h1000, 15'd20000, 1'b1, '{24'd55, 24'd66, 1'b1, 1'b1}, 1'b1,
        '{24'd0, 24'd0, 1'b1, 23'd0, 1'b0, 1'b0}},
      '{16'h1000, 15'd20000, 1'b0, '{24'd777, -24'sd777, 1'b0, 1'b1}, 1'b0, '0}
    };

    // Drive every input to a known value and match the shadow state to reset.
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.left_in   = '0;
    in_ch.right_in  = '0;
    in_ch.silent_in = 1'b0;
    in_ch.block_end = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_POLE_COEF;
    cfg_data        = '0;
    pole_r          = '0;
    gain_r          = GAIN_UNITY;
    byp_r           = 1'b0;
    left_hist       = '0;
    right_hist      = '0;
    run_peak        = '0;
    last_peak       = '0;
    mismatch_cnt    = 0;
    snd_idle_pct    = 0;
    rcv_stall_pct   = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reprogram only where the row's setting differs.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].pole != pole_r || dir_tab[r].gain != gain_r || dir_tab[r].byp != byp_r)
        load_config(dir_tab[r].pole, dir_tab[r].gain, dir_tab[r].byp);
      send_frame(dir_tab[r].frame, dir_tab[r].lit, dir_tab[r].res);
    end

    // Random part: each segment gets a fresh setting and one of four idle patterns,
    // so gaps land on every step of the block's multiply sequence.
    for (int seg = 0; seg < N_SEG; seg++) begin
      case ($urandom_range(4))
        0:       pole = '0;
        1:       pole = '1;
        2:       pole = COEF_BITS'(16'hFFFF - $urandom_range(255));
        default: pole = COEF_BITS'($urandom);
      endcase
      case ($urandom_range(7))
        0:       gain = '0;
        1:       gain = GMAX;
        2:       gain = GAIN_BITS'(1);
        3, 4:    gain = GAIN_UNITY;
        default: gain = GAIN_BITS'($urandom);
      endcase
      load_config(pole, gain, $urandom_range(4) == 0);

      case (seg % 4)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
        default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
      endcase

      for (int i = 0; i < SEG_ITEMS; i++) begin
        // Once, halfway through a segment, hold off until the block is empty.
        if (seg == HOLD_SEG && i == SEG_ITEMS / 2) drain_results();
        f.left   = rand_sample();
        f.right  = rand_sample();
        f.silent = ($urandom_range(7) == 0);
        f.last   = ($urandom_range(5) == 0);
        send_frame(f, 1'b0, '0);
      end
    end

    // Collect the remaining results, then give stray ones time to show up.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("** stereo_one_pole_lowpass_gain_top: PASSED **");
    else
      $display("** stereo_one_pole_lowpass_gain_top: FAILED **");
    $finish;
  end

endmodule
